// ===== rtl/kpd_pkg.sv =====
package kpd_pkg;

    // Key codes from the row/column scan
    localparam logic [7:0] KEY_CLEAR = 8'h12;
    localparam logic [7:0] KEY_ENTER = 8'h18;
    localparam logic [7:0] KEY_ZERO  = 8'h14;
    localparam logic [7:0] KEY_ONE   = 8'h88;
    localparam logic [7:0] KEY_TWO   = 8'h84;
    localparam logic [7:0] KEY_THREE = 8'h82;
    localparam logic [7:0] KEY_FOUR  = 8'h48;
    localparam logic [7:0] KEY_FIVE  = 8'h44;
    localparam logic [7:0] KEY_SIX   = 8'h42;
    localparam logic [7:0] KEY_SEVEN = 8'h28;
    localparam logic [7:0] KEY_EIGHT = 8'h24;
    localparam logic [7:0] KEY_NINE  = 8'h22;

    // Item kinds carried on tuser
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam int unsigned NUM_SLOTS = 4;
    localparam int unsigned OUT_BYTES = 5;

    typedef logic [7:0]  t_code;
    typedef logic [3:0]  t_digit;
    typedef logic [13:0] t_value;
    typedef logic [2:0]  t_count;

    typedef struct packed {
        logic   valid;
        t_digit digit;
    } t_key_digit;

    // One result item, as the state looks after the step
    typedef struct packed {
        logic   publish_mark;
        t_count entry_count;
        t_value entered_value;
        t_digit digit_ones;
        t_digit digit_tens;
        t_digit digit_hundreds;
        t_digit digit_thousands;
    } t_result;

    // Scan code to decimal digit; valid low for non-digit codes
    function automatic t_key_digit key_digit(input t_code code);
        t_key_digit kd;
        kd.valid = 1'b1;
        case (code)
            KEY_ONE:   kd.digit = 4'd1;
            KEY_TWO:   kd.digit = 4'd2;
            KEY_THREE: kd.digit = 4'd3;
            KEY_FOUR:  kd.digit = 4'd4;
            KEY_FIVE:  kd.digit = 4'd5;
            KEY_SIX:   kd.digit = 4'd6;
            KEY_SEVEN: kd.digit = 4'd7;
            KEY_EIGHT: kd.digit = 4'd8;
            KEY_NINE:  kd.digit = 4'd9;
            KEY_ZERO:  kd.digit = 4'd0;
            default: begin
                kd.valid = 1'b0;
                kd.digit = 4'd0;
            end
        endcase
        return kd;
    endfunction

endpackage

// ===== rtl/kpd_tick.sv =====
module kpd_tick
    import kpd_pkg::*;
(
    input  t_code  i_codes [NUM_SLOTS],
    input  t_count i_held,
    output t_digit o_digits [NUM_SLOTS],
    output t_value o_value
);

    t_count     pad;
    t_code      slots   [NUM_SLOTS];
    t_key_digit slot_kd [NUM_SLOTS];

    // Right-justify the held codes, zero key in front
    always_comb begin
        pad = (i_held < 3'd4) ? 3'(3'd4 - i_held) : 3'd0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (3'(i) < pad) begin
                slots[i] = KEY_ZERO;
            end else begin
                slots[i] = i_codes[2'(3'(i) - pad)];
            end
        end
    end

    // Decode each slot; non-digit codes read as 0
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_kd[i]  = key_digit(slots[i]);
            o_digits[i] = slot_kd[i].digit;
        end
    end

    assign o_value = 14'(14'(o_digits[0]) * 14'd1000)
                   + 14'(14'(o_digits[1]) * 14'd100)
                   + 14'(14'(o_digits[2]) * 14'd10)
                   + 14'(o_digits[3]);

endmodule

// ===== rtl/kpd_core.sv =====
module kpd_core
    import kpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_op,
    input  t_code   i_code,
    output t_result o_next
);

    t_code  r_codes  [NUM_SLOTS];
    t_count r_held;
    logic   r_pub;
    t_value r_value;
    t_digit r_digits [NUM_SLOTS];

    t_code  n_codes  [NUM_SLOTS];
    t_count n_held;
    logic   n_pub;
    t_value n_value;
    t_digit n_digits [NUM_SLOTS];

    t_digit     tick_digits [NUM_SLOTS];
    t_value     tick_value;
    t_code      base_codes  [NUM_SLOTS];
    t_count     base_held;
    t_key_digit in_key;

    kpd_tick u_tick (
        .i_codes  (r_codes),
        .i_held   (r_held),
        .o_digits (tick_digits),
        .o_value  (tick_value)
    );

    assign in_key = key_digit(i_code);

    // Next state for one key event or tick
    always_comb begin
        n_codes  = r_codes;
        n_held   = r_held;
        n_pub    = r_pub;
        n_value  = r_value;
        n_digits = r_digits;
        // digit after publish restarts the buffer
        base_held = r_pub ? 3'd0 : r_held;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            base_codes[i] = r_pub ? KEY_ZERO : r_codes[i];
        end

        if (i_op == OP_TICK) begin
            n_digits = tick_digits;
            n_value  = tick_value;
        end else if (i_code == KEY_CLEAR) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                n_codes[i] = KEY_ZERO;
            end
            n_held = 3'd0;
            n_pub  = 1'b0;
        end else if (i_code == KEY_ENTER) begin
            n_pub = 1'b1;
        end else if (in_key.valid) begin
            n_pub   = 1'b0;
            n_codes = base_codes;
            n_held  = base_held;
            if (base_held < 3'd4) begin
                n_codes[base_held[1:0]] = i_code;
                n_held = 3'(base_held + 3'd1);
            end else if (r_value == '0) begin
                // full buffer with zero value: start over with this digit
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    n_codes[i] = KEY_ZERO;
                end
                n_codes[0] = i_code;
                n_held     = 3'd1;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_codes[i]  <= KEY_ZERO;
                r_digits[i] <= '0;
            end
            r_held  <= '0;
            r_pub   <= 1'b0;
            r_value <= '0;
        end else if (i_step) begin
            r_codes  <= n_codes;
            r_held   <= n_held;
            r_pub    <= n_pub;
            r_value  <= n_value;
            r_digits <= n_digits;
        end
    end

    assign o_next.digit_thousands = n_digits[0];
    assign o_next.digit_hundreds  = n_digits[1];
    assign o_next.digit_tens      = n_digits[2];
    assign o_next.digit_ones      = n_digits[3];
    assign o_next.entered_value   = n_value;
    assign o_next.entry_count     = n_held;
    assign o_next.publish_mark    = n_pub;

endmodule

// ===== rtl/keypad_four_digit_entry.sv =====
// Channel | Dir | tdata (low bit up)                                  | tuser
// s       | in  | scan_code[7:0]                                      | opcode (0 key, 1 tick)
// m       | out | thousands, hundreds, tens, ones (4b each),          | -
//         |     | entered_value[13:0], entry_count[2:0],              |
//         |     | publish_mark, 6 zero bits                           |
//
// Two register stages: an input register, then the state update and result
// register; one result per item, passing from the input register to the result
// register. Sustained rate is one item per cycle while the output is not stalled.
// Synchronous active-low reset empties both stages and returns the entry
// buffer to four zero keys. The input register can still take an item while a
// result waits, and stalls only when both stages are full and the result is not taken.
module keypad_four_digit_entry
    import kpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // scan_code
    input  logic        i_s_tuser,   // opcode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // thousands, hundreds, tens, ones, value, count, publish
);

    logic    r_in_valid;
    logic    r_in_op;
    t_code   r_in_code;
    logic    r_out_valid;
    t_result r_out;

    logic    advance;
    t_result next_result;

    // Item moves from the input register into the result register
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_op   <= i_s_tuser;
            r_in_code <= i_s_tdata;
        end
    end

    kpd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_op    (r_in_op),
        .i_code  (r_in_code),
        .o_next  (next_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= next_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(8 * OUT_BYTES - $bits(t_result))'(0), r_out};

endmodule

// ===== rtl/kpd_checker.sv =====
module kpd_checker
    import kpd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata
);

    // A stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // Input stalls only behind a stalled result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input stalled without a waiting result");

    // Count never exceeds four slots
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[32:30] <= 3'd4)
        else $error("entry count above four");

    // Every decoded digit is decimal
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[3:0] <= 4'd9 && o_m_tdata[7:4] <= 4'd9
                    && o_m_tdata[11:8] <= 4'd9 && o_m_tdata[15:12] <= 4'd9)
        else $error("digit out of range");

    // Value agrees with the digits shown beside it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[29:16] ==
            14'(14'(o_m_tdata[3:0]) * 14'd1000) + 14'(14'(o_m_tdata[7:4]) * 14'd100)
            + 14'(14'(o_m_tdata[11:8]) * 14'd10) + 14'(o_m_tdata[15:12]))
        else $error("value does not match digits");

endmodule

bind keypad_four_digit_entry kpd_checker u_kpd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== bench/keypad_four_digit_entry_check.sv =====
// Watches both stream channels of the keypad entry block, keeps its own copy of
// the entry buffer, and compares every output transfer with the oldest prediction.
module keypad_four_digit_entry_check
    import kpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // scan_code
    input  logic        i_s_tuser,   // opcode
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // thousands, hundreds, tens, ones, value, count, publish
    output int          o_fail_count,
    output int          o_pending
);

    // Shadow copy of the entry buffer
    t_code   codes [NUM_SLOTS];
    t_count  held;
    logic    publish;
    t_value  value;
    t_digit  digs [NUM_SLOTS];

    t_result entry_snapshots [$];
    int      fail_count = 0;

    // Digit value of a scan code, -1 when the code is no digit key
    function automatic int code_to_digit(input t_code c);
        case (c)
            KEY_ZERO:  return 0;
            KEY_ONE:   return 1;
            KEY_TWO:   return 2;
            KEY_THREE: return 3;
            KEY_FOUR:  return 4;
            KEY_FIVE:  return 5;
            KEY_SIX:   return 6;
            KEY_SEVEN: return 7;
            KEY_EIGHT: return 8;
            KEY_NINE:  return 9;
            default:   return -1;
        endcase
    endfunction

    task automatic clear_codes();
        for (int i = 0; i < NUM_SLOTS; i++) codes[i] = KEY_ZERO;
    endtask

    // Advance the shadow buffer by one key event or tick
    task automatic step_entry_buffer(input logic op, input t_code code);
        int    pad;
        int    d;
        int    acc;
        t_code slot;
        if (op == OP_KEY) begin
            if (code == KEY_CLEAR) begin
                clear_codes();
                held = '0;
                publish = 1'b0;
            end else if (code == KEY_ENTER) begin
                publish = 1'b1;
            end else if (code_to_digit(code) >= 0) begin
                // a new digit after enter starts a fresh entry
                if (publish) begin
                    publish = 1'b0;
                    held = '0;
                    clear_codes();
                end
                if (held < NUM_SLOTS) begin
                    codes[held[1:0]] = code;
                    held = held + 3'd1;
                end else if (value == '0) begin
                    clear_codes();
                    codes[0] = code;
                    held = 3'd1;
                end
            end
        end else begin
            // right-justify held digits, zero keys in front
            pad = (held < NUM_SLOTS) ? NUM_SLOTS - held : 0;
            acc = 0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot = (i < pad) ? KEY_ZERO : codes[(i - pad) % NUM_SLOTS];
                d = code_to_digit(slot);
                if (d < 0) d = 0;
                digs[i] = t_digit'(d);
                acc = acc * 10 + d;
            end
            value = t_value'(acc);
        end
    endtask

    task automatic report_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // Prediction on input transfers, comparison on output transfers
    always @(posedge i_clk) begin
        t_result snap;
        t_result got;
        if (!i_rst_n) begin
            clear_codes();
            held = '0;
            publish = 1'b0;
            value = '0;
            for (int i = 0; i < NUM_SLOTS; i++) digs[i] = '0;
            entry_snapshots.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                step_entry_buffer(i_s_tuser, i_s_tdata);
                snap.digit_thousands = digs[0];
                snap.digit_hundreds  = digs[1];
                snap.digit_tens      = digs[2];
                snap.digit_ones      = digs[3];
                snap.entered_value   = value;
                snap.entry_count     = held;
                snap.publish_mark    = publish;
                entry_snapshots.push_back(snap);
            end
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[33:0]);
                if (entry_snapshots.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result transfer, expected none, actual %h",
                             $time, i_m_tdata);
                end else begin
                    snap = entry_snapshots.pop_front();
                    report_field("digit_thousands", snap.digit_thousands, got.digit_thousands);
                    report_field("digit_hundreds", snap.digit_hundreds, got.digit_hundreds);
                    report_field("digit_tens", snap.digit_tens, got.digit_tens);
                    report_field("digit_ones", snap.digit_ones, got.digit_ones);
                    report_field("entered_value", snap.entered_value, got.entered_value);
                    report_field("entry_count", snap.entry_count, got.entry_count);
                    report_field("publish_mark", snap.publish_mark, got.publish_mark);
                    report_field("tdata padding", 0, i_m_tdata[39:34]);
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= entry_snapshots.size();
    end

endmodule

// ===== bench/keypad_four_digit_entry_test.sv =====
// Stimulus and verdict for the keypad entry block; checking lives in the checker.
module keypad_four_digit_entry_test;
    import kpd_pkg::*;

    localparam int RANDOM_ITEMS   = 900;
    localparam int HOLD_CYCLES    = 100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    logic        i_clk    = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;    // scan_code
    logic        s_tuser  = 1'b0;  // opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // thousands, hundreds, tens, ones, value, count, publish

    int fail_count;
    int pending;
    int burst_left  = 0;
    int idle_cycles = 0;
    logic stress_go = 1'b0;

    // receiver pattern state
    int   rx_mode   = 0;
    int   rx_left   = 0;
    int   rx_phase  = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    always #10 i_clk = ~i_clk;

    keypad_four_digit_entry i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    keypad_four_digit_entry_check i_check (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offer one item and wait for its transfer; bursts with random gaps between
    task automatic send_item(input logic op, input t_code code);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= code;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // Receiver: one long hold-off, otherwise rotating stall patterns
    always @(posedge i_clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (stress_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(0, 2);
                rx_left <= $urandom_range(64, 256);
            end else begin
                rx_left <= rx_left - 1;
            end
            rx_phase <= rx_phase + 1;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= (rx_phase % 4) != 3;
            endcase
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (rst_n && !(s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end else begin
            idle_cycles <= 0;
        end
    end

    // Stimulus
    initial begin
        t_code digit_codes [10];
        int    counted;
        int    r;
        logic  op;
        t_code code;
        digit_codes = '{KEY_ZERO, KEY_ONE, KEY_TWO, KEY_THREE, KEY_FOUR,
                        KEY_FIVE, KEY_SIX, KEY_SEVEN, KEY_EIGHT, KEY_NINE};
        counted = 0;

        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty tick, odd codes, full-buffer cases, enter and clear
        send_item(OP_TICK, 8'hFF);
        send_item(OP_KEY, 8'h00);
        send_item(OP_KEY, 8'hFF);
        send_item(OP_KEY, KEY_ONE);
        send_item(OP_KEY, KEY_TWO);
        send_item(OP_KEY, KEY_THREE);
        send_item(OP_KEY, KEY_FOUR);
        send_item(OP_KEY, KEY_FIVE);    // full, value zero: restarts
        send_item(OP_TICK, 8'h00);
        send_item(OP_KEY, KEY_SIX);
        send_item(OP_KEY, KEY_SEVEN);
        send_item(OP_KEY, KEY_EIGHT);
        send_item(OP_KEY, KEY_NINE);    // full, value nonzero: dropped
        send_item(OP_TICK, 8'h5A);
        send_item(OP_KEY, KEY_ENTER);
        send_item(OP_KEY, KEY_NINE);    // digit after enter starts over
        send_item(OP_KEY, KEY_ZERO);
        send_item(OP_TICK, 8'hA5);
        send_item(OP_KEY, KEY_ENTER);
        send_item(OP_KEY, KEY_ENTER);
        send_item(OP_KEY, KEY_CLEAR);
        send_item(OP_TICK, 8'h00);
        send_item(OP_KEY, KEY_CLEAR);
        send_item(OP_TICK, 8'hFF);

        // random: mostly digit entry with enter, clear and ticks, some noise
        while (counted < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                op = OP_KEY;
                code = digit_codes[$urandom_range(0, 9)];
            end else if (r < 60) begin
                op = OP_KEY;
                code = KEY_ENTER;
            end else if (r < 66) begin
                op = OP_KEY;
                code = KEY_CLEAR;
            end else if (r < 86) begin
                op = OP_TICK;
                code = t_code'($urandom);
            end else begin
                op = 1'($urandom_range(0, 1));
                code = t_code'($urandom);
            end
            send_item(op, code);
            counted++;
            if (counted == 100) stress_go <= 1'b1;
        end

        // drain
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/kpd_pkg.sv
rtl/kpd_tick.sv
rtl/kpd_core.sv
rtl/keypad_four_digit_entry.sv
rtl/kpd_checker.sv
bench/keypad_four_digit_entry_check.sv
bench/keypad_four_digit_entry_test.sv
